// ----- rtl/slcd_pkg.sv -----
// Shared types and constants of the spot light cone diffuse block.
package slcd_pkg;

    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    localparam logic [2:0] REG_LIGHT_POS_X     = 3'd0;
    localparam logic [2:0] REG_LIGHT_POS_Y     = 3'd1;
    localparam logic [2:0] REG_LIGHT_POS_Z     = 3'd2;
    localparam logic [2:0] REG_LIGHT_AXIS      = 3'd3;
    localparam logic [2:0] REG_COS_INNER       = 3'd4;
    localparam logic [2:0] REG_COS_OUTER       = 3'd5;
    localparam logic [2:0] REG_LIGHT_INTENSITY = 3'd6;

    localparam logic [47:0] AXIS_RESET      = 48'd16384;
    localparam logic [15:0] COS_INNER_RESET = 16'd15826;
    localparam logic [15:0] COS_OUTER_RESET = 16'd15642;
    localparam logic [31:0] INTENSITY_RESET = 32'd65536;

    localparam logic [1:0] ZONE_INNER    = 2'd0;
    localparam logic [1:0] ZONE_PENUMBRA = 2'd1;
    localparam logic [1:0] ZONE_OUTSIDE  = 2'd2;

    localparam logic [31:0] VALUE_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [16:0]        visibility;
    } t_in_item;

    typedef struct packed {
        logic [31:0] light_value;
        logic [1:0]  cone_zone;
        logic        saturated;
    } t_out_item;

endpackage

// ----- rtl/slcd_sqrt_cell.sv -----
// One digit cell of the pipelined square root chain.
module slcd_sqrt_cell #(
    parameter int REM_W  = 62,
    parameter int ROOT_W = 31,
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [ROOT_W-1:0] i_root,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [REM_W-1:0]  o_rem,
    output logic [ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int CW = REM_W + 1;

    logic [CW-1:0]     w_trial;
    logic [CW-1:0]     w_rem;
    logic              w_take;
    logic              r_valid;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [SIDE_W-1:0] r_side;

    assign w_trial = (CW'(i_root) << (BIT + 1)) | (CW'(1) << (2 * BIT));
    assign w_rem   = CW'(i_rem);
    assign w_take  = w_rem >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_take ? REM_W'(w_rem - w_trial) : i_rem;
            r_root <= w_take ? (i_root | (ROOT_W'(1) << BIT)) : i_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;
endmodule

// ----- rtl/slcd_div_cell.sv -----
// One quotient bit cell of a pipelined restoring divider chain.
module slcd_div_cell #(
    parameter int REM_W  = 47,
    parameter int DIV_W  = 31,
    parameter int Q_W    = 17,
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [DIV_W-1:0]  i_div,
    input  logic [Q_W-1:0]    i_quo,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [REM_W-1:0]  o_rem,
    output logic [DIV_W-1:0]  o_div,
    output logic [Q_W-1:0]    o_quo,
    output logic [SIDE_W-1:0] o_side
);
    localparam int T_W = DIV_W + BIT;
    localparam int CW  = (T_W > REM_W) ? T_W : REM_W;

    logic [CW-1:0]     w_trial;
    logic [CW-1:0]     w_rem;
    logic              w_take;
    logic              r_valid;
    logic [REM_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_div;
    logic [Q_W-1:0]    r_quo;
    logic [SIDE_W-1:0] r_side;

    assign w_trial = CW'(i_div) << BIT;
    assign w_rem   = CW'(i_rem);
    assign w_take  = w_rem >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_take ? REM_W'(w_rem - w_trial) : i_rem;
            r_quo  <= w_take ? (i_quo | (Q_W'(1) << BIT)) : i_quo;
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_quo   = r_quo;
    assign o_side  = r_side;
endmodule

// ----- rtl/spot_light_cone_diffuse.sv -----
// Top level of the spot light cone diffuse block.
//
// Input channel: i_valid / o_stall with payload i_in_item (point, normal,
// visibility). Output channel: o_valid / i_stall with payload o_out_item
// (light value, cone zone, saturated). A transfer happens at a rising edge
// with valid high and stall low.
// Throughput is one item per cycle while o_stall is low. Each result passes
// in order through six front stages (difference, scaling, products, sums,
// partial products, numerator), a 31-cell square root chain, a 17-cell
// cosine divider chain, four stages for zone and operand products, a
// 32-cell divider chain and the output register.
// When the receiver stalls with a result held, the whole chain holds and
// o_stall rises in the same cycle; it falls as soon as the result is taken.
// Synchronous reset clears all valid bits and loads the register defaults;
// no clearing pass is needed.
// Registers are written through the APB port at byte address 8*index and
// must only change while no transfer is in flight.
module spot_light_cone_diffuse
    import slcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_in_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_out_item
);
    localparam int SQ_CELLS = 31;
    localparam int CD_CELLS = 17;
    localparam int DV_CELLS = 32;

    typedef struct packed {
        logic [65:0] s;
        logic [80:0] num0;
        logic [46:0] dmag;
        logic        dneg;
        logic        zero;
    } t_sq_side;

    typedef struct packed {
        logic [65:0] s;
        logic [80:0] num0;
        logic        dneg;
        logic        zero;
    } t_cd_side;

    typedef struct packed {
        logic [1:0] zone;
        logic       zero;
        logic       sat;
    } t_dv_side;

    // configuration registers
    logic [31:0] r_lp_x, r_lp_y, r_lp_z, r_inten;
    logic [47:0] r_axis;
    logic [15:0] r_ci, r_co;
    logic [2:0]  w_idx;

    assign w_idx  = paddr[5:3];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp_x  <= '0;
            r_lp_y  <= '0;
            r_lp_z  <= '0;
            r_axis  <= AXIS_RESET;
            r_ci    <= COS_INNER_RESET;
            r_co    <= COS_OUTER_RESET;
            r_inten <= INTENSITY_RESET;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_LIGHT_POS_X:     r_lp_x  <= pwdata[31:0];
                REG_LIGHT_POS_Y:     r_lp_y  <= pwdata[31:0];
                REG_LIGHT_POS_Z:     r_lp_z  <= pwdata[31:0];
                REG_LIGHT_AXIS:      r_axis  <= pwdata[47:0];
                REG_COS_INNER:       r_ci    <= pwdata[15:0];
                REG_COS_OUTER:       r_co    <= pwdata[15:0];
                REG_LIGHT_INTENSITY: r_inten <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_LIGHT_POS_X:     prdata = CFG_DATA_W'(r_lp_x);
            REG_LIGHT_POS_Y:     prdata = CFG_DATA_W'(r_lp_y);
            REG_LIGHT_POS_Z:     prdata = CFG_DATA_W'(r_lp_z);
            REG_LIGHT_AXIS:      prdata = CFG_DATA_W'(r_axis);
            REG_COS_INNER:       prdata = CFG_DATA_W'(r_ci);
            REG_COS_OUTER:       prdata = CFG_DATA_W'(r_co);
            REG_LIGHT_INTENSITY: prdata = CFG_DATA_W'(r_inten);
            default:             prdata = '0;
        endcase
    end

    // pipeline advance
    logic en;
    logic r_out_valid;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    logic signed [15:0] w_ax, w_ay, w_az;
    assign w_ax = signed'(r_axis[15:0]);
    assign w_ay = signed'(r_axis[31:16]);
    assign w_az = signed'(r_axis[47:32]);

    // stage 1: difference vector
    logic               r_v1;
    logic signed [32:0] r1_dx, r1_dy, r1_dz;
    logic signed [15:0] r1_nx, r1_ny, r1_nz;
    logic [16:0]        r1_vis;

    // stage 2: magnitudes and scaled vector
    logic               r_v2;
    logic [31:0]        r2_mx, r2_my, r2_mz;
    logic               r2_gx, r2_gy, r2_gz;
    logic [29:0]        r2_nx, r2_ny, r2_nz;
    logic signed [15:0] r2_px, r2_py, r2_pz;
    logic [48:0]        r2_iv;
    logic [31:0]        w1_mx, w1_my, w1_mz;
    logic [1:0]         w1_sh;

    // stage 3: products
    logic               r_v3;
    logic [63:0]        r3_sqx, r3_sqy, r3_sqz;
    logic [59:0]        r3_dsx, r3_dsy, r3_dsz;
    logic signed [46:0] r3_pdx, r3_pdy, r3_pdz;
    logic signed [31:0] r3_pnx, r3_pny, r3_pnz;
    logic [48:0]        r3_iv;
    logic signed [30:0] w2_dx, w2_dy, w2_dz;

    // stage 4: sums
    logic               r_v4;
    logic [65:0]        r4_s;
    logic [61:0]        r4_s2;
    logic signed [48:0] r4_dot;
    logic [31:0]        r4_m;
    logic               r4_zero;
    logic [48:0]        r4_iv;
    logic signed [33:0] w3_nl;

    // stage 5: numerator partial products
    logic               r_v5;
    logic [56:0]        r5_pl;
    logic [55:0]        r5_ph;
    logic [65:0]        r5_s;
    logic [61:0]        r5_s2;
    logic [46:0]        r5_dmag;
    logic               r5_dneg;
    logic               r5_zero;

    // stage 6: numerator
    logic               r_v6;
    t_sq_side           r6_side;
    logic [61:0]        r6_s2;

    always_comb begin
        w1_mx = r1_dx[32] ? 32'(-r1_dx) : r1_dx[31:0];
        w1_my = r1_dy[32] ? 32'(-r1_dy) : r1_dy[31:0];
        w1_mz = r1_dz[32] ? 32'(-r1_dz) : r1_dz[31:0];
        if (w1_mx[31] || w1_my[31] || w1_mz[31]) begin
            w1_sh = 2'd2;
        end else if (w1_mx[30] || w1_my[30] || w1_mz[30]) begin
            w1_sh = 2'd1;
        end else begin
            w1_sh = 2'd0;
        end
    end

    assign w2_dx = r2_gx ? -signed'({1'b0, r2_nx}) : signed'({1'b0, r2_nx});
    assign w2_dy = r2_gy ? -signed'({1'b0, r2_ny}) : signed'({1'b0, r2_ny});
    assign w2_dz = r2_gz ? -signed'({1'b0, r2_nz}) : signed'({1'b0, r2_nz});
    assign w3_nl = 34'(r3_pnx) + 34'(r3_pny) + 34'(r3_pnz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx  <= 33'(i_in_item.pos_x) - 33'(signed'(r_lp_x));
            r1_dy  <= 33'(i_in_item.pos_y) - 33'(signed'(r_lp_y));
            r1_dz  <= 33'(i_in_item.pos_z) - 33'(signed'(r_lp_z));
            r1_nx  <= i_in_item.norm_x;
            r1_ny  <= i_in_item.norm_y;
            r1_nz  <= i_in_item.norm_z;
            r1_vis <= i_in_item.visibility;

            r2_mx <= w1_mx;
            r2_my <= w1_my;
            r2_mz <= w1_mz;
            r2_gx <= r1_dx[32];
            r2_gy <= r1_dy[32];
            r2_gz <= r1_dz[32];
            r2_nx <= 30'(w1_mx >> w1_sh);
            r2_ny <= 30'(w1_my >> w1_sh);
            r2_nz <= 30'(w1_mz >> w1_sh);
            r2_px <= r1_nx;
            r2_py <= r1_ny;
            r2_pz <= r1_nz;
            r2_iv <= 49'(r_inten) * 49'(r1_vis);

            r3_sqx <= 64'(r2_mx) * 64'(r2_mx);
            r3_sqy <= 64'(r2_my) * 64'(r2_my);
            r3_sqz <= 64'(r2_mz) * 64'(r2_mz);
            r3_dsx <= 60'(r2_nx) * 60'(r2_nx);
            r3_dsy <= 60'(r2_ny) * 60'(r2_ny);
            r3_dsz <= 60'(r2_nz) * 60'(r2_nz);
            r3_pdx <= 47'(w_ax) * 47'(w2_dx);
            r3_pdy <= 47'(w_ay) * 47'(w2_dy);
            r3_pdz <= 47'(w_az) * 47'(w2_dz);
            r3_pnx <= 32'(r2_px) * 32'(w_ax);
            r3_pny <= 32'(r2_py) * 32'(w_ay);
            r3_pnz <= 32'(r2_pz) * 32'(w_az);
            r3_iv  <= r2_iv;

            r4_s    <= 66'(r3_sqx) + 66'(r3_sqy) + 66'(r3_sqz);
            r4_zero <= (r3_sqx == '0) && (r3_sqy == '0) && (r3_sqz == '0);
            r4_s2   <= 62'(r3_dsx) + 62'(r3_dsy) + 62'(r3_dsz);
            r4_dot  <= 49'(r3_pdx) + 49'(r3_pdy) + 49'(r3_pdz);
            r4_m    <= w3_nl[33] ? 32'(-w3_nl) : '0;
            r4_iv   <= r3_iv;

            r5_pl   <= 57'(r4_iv[24:0]) * 57'(r4_m);
            r5_ph   <= 56'(r4_iv[48:25]) * 56'(r4_m);
            r5_s    <= r4_s;
            r5_s2   <= r4_s2;
            r5_dmag <= r4_dot[48] ? 47'(-r4_dot) : r4_dot[46:0];
            r5_dneg <= r4_dot[48];
            r5_zero <= r4_zero;

            r6_side.s    <= r5_s;
            r6_side.num0 <= 81'(r5_pl) + (81'(r5_ph) << 25);
            r6_side.dmag <= r5_dmag;
            r6_side.dneg <= r5_dneg;
            r6_side.zero <= r5_zero;
            r6_s2        <= r5_s2;
        end
    end

    // square root chain
    logic                         w_sq_v    [0:SQ_CELLS];
    logic [61:0]                  w_sq_rem  [0:SQ_CELLS];
    logic [30:0]                  w_sq_root [0:SQ_CELLS];
    logic [$bits(t_sq_side)-1:0]  w_sq_side [0:SQ_CELLS];

    assign w_sq_v[0]    = r_v6;
    assign w_sq_rem[0]  = r6_s2;
    assign w_sq_root[0] = '0;
    assign w_sq_side[0] = r6_side;

    for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sq
        slcd_sqrt_cell #(
            .REM_W  (62),
            .ROOT_W (31),
            .BIT    (SQ_CELLS - 1 - k),
            .SIDE_W ($bits(t_sq_side))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_sq_v[k]),
            .i_rem   (w_sq_rem[k]),
            .i_root  (w_sq_root[k]),
            .i_side  (w_sq_side[k]),
            .o_valid (w_sq_v[k+1]),
            .o_rem   (w_sq_rem[k+1]),
            .o_root  (w_sq_root[k+1]),
            .o_side  (w_sq_side[k+1])
        );
    end

    // cosine divider chain
    t_sq_side                     w_sq_out;
    t_cd_side                     w_cd_in;
    logic                         w_cd_v    [0:CD_CELLS];
    logic [46:0]                  w_cd_rem  [0:CD_CELLS];
    logic [30:0]                  w_cd_div  [0:CD_CELLS];
    logic [16:0]                  w_cd_quo  [0:CD_CELLS];
    logic [$bits(t_cd_side)-1:0]  w_cd_side [0:CD_CELLS];

    assign w_sq_out     = t_sq_side'(w_sq_side[SQ_CELLS]);
    assign w_cd_in.s    = w_sq_out.s;
    assign w_cd_in.num0 = w_sq_out.num0;
    assign w_cd_in.dneg = w_sq_out.dneg;
    assign w_cd_in.zero = w_sq_out.zero;
    assign w_cd_v[0]    = w_sq_v[SQ_CELLS];
    assign w_cd_rem[0]  = w_sq_out.dmag;
    assign w_cd_div[0]  = w_sq_root[SQ_CELLS];
    assign w_cd_quo[0]  = '0;
    assign w_cd_side[0] = w_cd_in;

    for (genvar k = 0; k < CD_CELLS; k++) begin : g_cd
        slcd_div_cell #(
            .REM_W  (47),
            .DIV_W  (31),
            .Q_W    (17),
            .BIT    (CD_CELLS - 1 - k),
            .SIDE_W ($bits(t_cd_side))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_cd_v[k]),
            .i_rem   (w_cd_rem[k]),
            .i_div   (w_cd_div[k]),
            .i_quo   (w_cd_quo[k]),
            .i_side  (w_cd_side[k]),
            .o_valid (w_cd_v[k+1]),
            .o_rem   (w_cd_rem[k+1]),
            .o_div   (w_cd_div[k+1]),
            .o_quo   (w_cd_quo[k+1]),
            .o_side  (w_cd_side[k+1])
        );
    end

    // zone decision and operand products
    t_cd_side           w_cd_out;
    logic signed [17:0] w_c, w_ci, w_co;
    logic [1:0]         w_zone;

    assign w_cd_out = t_cd_side'(w_cd_side[CD_CELLS]);
    assign w_c  = w_cd_out.dneg ? -signed'({1'b0, w_cd_quo[CD_CELLS]})
                                : signed'({1'b0, w_cd_quo[CD_CELLS]});
    assign w_ci = 18'(signed'(r_ci));
    assign w_co = 18'(signed'(r_co));

    always_comb begin
        if (w_c >= w_ci) begin
            w_zone = ZONE_INNER;
        end else if (w_c > w_co) begin
            w_zone = ZONE_PENUMBRA;
        end else begin
            w_zone = ZONE_OUTSIDE;
        end
    end

    logic        r_vz, r_vp, r_vw, r_vs;
    logic [1:0]  rz_zone, rp_zone, rw_zone, rs_zone;
    logic        rz_zero, rp_zero, rw_zero, rs_zero;
    logic [16:0] rz_fn, rz_fd;
    logic [80:0] rz_num0;
    logic [65:0] rz_s;
    logic [43:0] rp_n0, rp_n1, rp_n2;
    logic [38:0] rp_d0, rp_d1, rp_d2;
    logic [97:0] rw_num, rs_num;
    logic [94:0] rw_den, rs_den;
    logic        rs_sat;
    t_dv_side    w_dv_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vz <= 1'b0;
            r_vp <= 1'b0;
            r_vw <= 1'b0;
            r_vs <= 1'b0;
        end else if (en) begin
            r_vz <= w_cd_v[CD_CELLS];
            r_vp <= r_vz;
            r_vw <= r_vp;
            r_vs <= r_vw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rz_zone <= w_zone;
            rz_zero <= w_cd_out.zero;
            rz_fn   <= (w_zone == ZONE_PENUMBRA) ? 17'(w_c - w_co) : 17'd1;
            rz_fd   <= (w_zone == ZONE_PENUMBRA) ? 17'(w_ci - w_co) : 17'd1;
            rz_num0 <= w_cd_out.num0;
            rz_s    <= w_cd_out.s;

            rp_n0   <= 44'(rz_num0[26:0]) * 44'(rz_fn);
            rp_n1   <= 44'(rz_num0[53:27]) * 44'(rz_fn);
            rp_n2   <= 44'(rz_num0[80:54]) * 44'(rz_fn);
            rp_d0   <= 39'(rz_s[21:0]) * 39'(rz_fd);
            rp_d1   <= 39'(rz_s[43:22]) * 39'(rz_fd);
            rp_d2   <= 39'(rz_s[65:44]) * 39'(rz_fd);
            rp_zone <= rz_zone;
            rp_zero <= rz_zero;

            rw_num  <= 98'(rp_n0) + (98'(rp_n1) << 27) + (98'(rp_n2) << 54);
            rw_den  <= (95'(rp_d0) + (95'(rp_d1) << 22) + (95'(rp_d2) << 44)) << 12;
            rw_zone <= rp_zone;
            rw_zero <= rp_zero;

            rs_sat  <= 127'(rw_num) >= (127'(rw_den) << 32);
            rs_num  <= rw_num;
            rs_den  <= rw_den;
            rs_zone <= rw_zone;
            rs_zero <= rw_zero;
        end
    end

    // final divider chain
    logic                         w_dv_v    [0:DV_CELLS];
    logic [97:0]                  w_dv_rem  [0:DV_CELLS];
    logic [94:0]                  w_dv_div  [0:DV_CELLS];
    logic [31:0]                  w_dv_quo  [0:DV_CELLS];
    logic [$bits(t_dv_side)-1:0]  w_dv_side [0:DV_CELLS];

    assign w_dv_in.zone = rs_zone;
    assign w_dv_in.zero = rs_zero;
    assign w_dv_in.sat  = rs_sat;
    assign w_dv_v[0]    = r_vs;
    assign w_dv_rem[0]  = rs_num;
    assign w_dv_div[0]  = rs_den;
    assign w_dv_quo[0]  = '0;
    assign w_dv_side[0] = w_dv_in;

    for (genvar k = 0; k < DV_CELLS; k++) begin : g_dv
        slcd_div_cell #(
            .REM_W  (98),
            .DIV_W  (95),
            .Q_W    (32),
            .BIT    (DV_CELLS - 1 - k),
            .SIDE_W ($bits(t_dv_side))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_dv_v[k]),
            .i_rem   (w_dv_rem[k]),
            .i_div   (w_dv_div[k]),
            .i_quo   (w_dv_quo[k]),
            .i_side  (w_dv_side[k]),
            .o_valid (w_dv_v[k+1]),
            .o_rem   (w_dv_rem[k+1]),
            .o_div   (w_dv_div[k+1]),
            .o_quo   (w_dv_quo[k+1]),
            .o_side  (w_dv_side[k+1])
        );
    end

    // output register
    t_dv_side  w_dv_out;
    t_out_item n_out;
    t_out_item r_out;

    assign w_dv_out = t_dv_side'(w_dv_side[DV_CELLS]);

    always_comb begin
        if (w_dv_out.zero) begin
            n_out.light_value = VALUE_MAX;
            n_out.cone_zone   = ZONE_INNER;
            n_out.saturated   = 1'b1;
        end else if (w_dv_out.zone == ZONE_OUTSIDE) begin
            n_out.light_value = '0;
            n_out.cone_zone   = ZONE_OUTSIDE;
            n_out.saturated   = 1'b0;
        end else if (w_dv_out.sat) begin
            n_out.light_value = VALUE_MAX;
            n_out.cone_zone   = w_dv_out.zone;
            n_out.saturated   = 1'b1;
        end else begin
            n_out.light_value = w_dv_quo[DV_CELLS];
            n_out.cone_zone   = w_dv_out.zone;
            n_out.saturated   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_dv_v[DV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_item = r_out;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_item.cone_zone == ZONE_OUTSIDE)
            |-> (o_out_item.light_value == '0 && !o_out_item.saturated))
        else $error("outside cone gives a nonzero value");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_item.saturated) |-> (o_out_item.light_value == VALUE_MAX))
        else $error("saturated result not clipped");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

// ----- tb/sv/slcd_checker.sv -----
// Checker of the spot light cone diffuse block: register copy, prediction and comparison.
`timescale 1ns / 100ps
module slcd_checker
    import slcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    input  logic                  i_valid,
    input  logic                  o_stall,
    input  t_in_item              i_in_item,
    input  logic                  o_valid,
    input  logic                  i_stall,
    input  t_out_item             o_out_item,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_results
);

    logic signed [31:0] lp_x, lp_y, lp_z;
    logic [47:0]        axis;
    logic signed [15:0] cos_in, cos_out;
    logic [31:0]        intensity;

    t_out_item light_q[$];

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r, c;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= v) r = c;
        end
        return r;
    endfunction

    function automatic t_out_item diffuse_of(t_in_item it);
        longint      d[3], dn[3], ax[3], nv[3];
        longint      dot, nl, cc, ci, co;
        logic [63:0] am, mx, s2, r, q, mm;
        logic [191:0] s, num, den, quo;
        int          sh;
        t_out_item   o;
        d[0] = longint'(it.pos_x) - longint'(lp_x);
        d[1] = longint'(it.pos_y) - longint'(lp_y);
        d[2] = longint'(it.pos_z) - longint'(lp_z);
        nv[0] = longint'(it.norm_x);
        nv[1] = longint'(it.norm_y);
        nv[2] = longint'(it.norm_z);
        s = '0;
        mx = '0;
        for (int k = 0; k < 3; k++) begin
            ax[k] = longint'($signed(axis[16*k +: 16]));
            am = (d[k] < 0) ? 64'(-d[k]) : 64'(d[k]);
            s = s + 192'(am) * 192'(am);
            if (am > mx) mx = am;
        end
        ci = longint'(cos_in);
        co = longint'(cos_out);
        if (s == 0) begin
            o.light_value = VALUE_MAX;
            o.cone_zone   = ZONE_INNER;
            o.saturated   = 1'b1;
            return o;
        end
        sh = 0;
        while ((mx >> sh) >= (64'd1 << 30)) sh++;
        s2 = '0;
        dot = 0;
        nl = 0;
        for (int k = 0; k < 3; k++) begin
            am = ((d[k] < 0) ? 64'(-d[k]) : 64'(d[k])) >> sh;
            dn[k] = (d[k] < 0) ? -longint'(am) : longint'(am);
            s2 = s2 + am * am;
            dot += ax[k] * dn[k];
            nl += nv[k] * ax[k];
        end
        r = floor_sqrt(s2);
        q = ((dot < 0) ? 64'(-dot) : 64'(dot)) / r;
        cc = (dot < 0) ? -longint'(q) : longint'(q);
        nl = -nl;
        mm = (nl > 0) ? 64'(nl) : 64'd0;
        num = 192'(intensity) * 192'(it.visibility) * 192'(mm);
        den = s << 12;
        if (cc >= ci) begin
            o.cone_zone = ZONE_INNER;
        end else if (cc > co) begin
            o.cone_zone = ZONE_PENUMBRA;
            num = num * 192'(cc - co);
            den = den * 192'(ci - co);
        end else begin
            o.light_value = '0;
            o.cone_zone   = ZONE_OUTSIDE;
            o.saturated   = 1'b0;
            return o;
        end
        quo = num / den;
        if (quo >= (192'd1 << 32)) begin
            o.light_value = VALUE_MAX;
            o.saturated   = 1'b1;
        end else begin
            o.light_value = quo[31:0];
            o.saturated   = 1'b0;
        end
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            lp_x      <= '0;
            lp_y      <= '0;
            lp_z      <= '0;
            axis      <= AXIS_RESET;
            cos_in    <= COS_INNER_RESET;
            cos_out   <= COS_OUTER_RESET;
            intensity <= INTENSITY_RESET;
            light_q.delete();
            o_errors  <= 0;
            o_results <= 0;
            o_pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_ADDR_W-1:3])
                    REG_LIGHT_POS_X:     lp_x      <= pwdata[31:0];
                    REG_LIGHT_POS_Y:     lp_y      <= pwdata[31:0];
                    REG_LIGHT_POS_Z:     lp_z      <= pwdata[31:0];
                    REG_LIGHT_AXIS:      axis      <= pwdata[47:0];
                    REG_COS_INNER:       cos_in    <= pwdata[15:0];
                    REG_COS_OUTER:       cos_out   <= pwdata[15:0];
                    REG_LIGHT_INTENSITY: intensity <= pwdata[31:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) light_q.push_back(diffuse_of(i_in_item));
            if (o_valid && !i_stall) begin
                o_results <= o_results + 1;
                if (light_q.size() == 0) begin
                    $error("result with no expected value: %h", o_out_item);
                    errs++;
                end else begin
                    want = light_q.pop_front();
                    if (want.light_value !== o_out_item.light_value) begin
                        $error("light_value expected %h actual %h",
                               want.light_value, o_out_item.light_value);
                        errs++;
                    end
                    if (want.cone_zone !== o_out_item.cone_zone) begin
                        $error("cone_zone expected %0d actual %0d",
                               want.cone_zone, o_out_item.cone_zone);
                        errs++;
                    end
                    if (want.saturated !== o_out_item.saturated) begin
                        $error("saturated expected %0d actual %0d",
                               want.saturated, o_out_item.saturated);
                        errs++;
                    end
                end
            end
            o_errors  <= o_errors + errs;
            o_pending <= light_q.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Stimulus and verdict for the spot light cone diffuse block.
`timescale 1ns / 100ps
module testbench;
    import slcd_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_in_item              i_in_item = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_out_item             o_out_item;
    int                    errors, pending, results;

    logic signed [31:0] lx, ly, lz;
    logic [47:0]        lax;
    logic               calm = 1'b0;
    int                 sent = 0;
    int                 phases = 0;
    int                 idle_cycles = 0;

    always #4 i_clk = ~i_clk;

    spot_light_cone_diffuse u_top (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_valid, .o_stall, .i_in_item, .o_valid, .i_stall, .o_out_item
    );

    slcd_checker u_checker (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .i_valid, .o_stall, .i_in_item, .o_valid, .i_stall, .o_out_item,
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always @(negedge i_clk) begin
        if (!i_rst_n || calm) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < 35);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= CFG_ADDR_W'({idx, 3'b000});
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic set_light(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [47:0] ax, logic [15:0] ci, logic [15:0] co,
                             logic [31:0] inten);
        drain();
        reg_write(REG_LIGHT_POS_X, {32'h0, px});
        reg_write(REG_LIGHT_POS_Y, {32'h0, py});
        reg_write(REG_LIGHT_POS_Z, {32'h0, pz});
        reg_write(REG_LIGHT_AXIS, {16'h0, ax});
        reg_write(REG_COS_INNER, {48'h0, ci});
        reg_write(REG_COS_OUTER, {48'h0, co});
        reg_write(REG_LIGHT_INTENSITY, {32'h0, inten});
        lx = px; ly = py; lz = pz; lax = ax;
        phases++;
    endtask

    task automatic send(t_in_item it);
        logic st;
        while (!calm && $urandom_range(99) < 35) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_item <= it;
        do begin
            #1 st = o_stall;
            @(posedge i_clk);
            if (st) @(negedge i_clk);
        end while (st);
        @(negedge i_clk);
        sent++;
    endtask

    function automatic t_in_item point_at(longint dx, longint dy, longint dz,
                                          logic [15:0] nx, logic [15:0] ny,
                                          logic [15:0] nz, logic [16:0] vis);
        t_in_item it;
        it.pos_x = 32'(longint'(lx) + dx);
        it.pos_y = 32'(longint'(ly) + dy);
        it.pos_z = 32'(longint'(lz) + dz);
        it.norm_x = nx;
        it.norm_y = ny;
        it.norm_z = nz;
        it.visibility = vis;
        return it;
    endfunction

    function automatic longint spread(longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    // along the axis with a random offset, normal roughly facing the light
    function automatic t_in_item cone_point();
        longint      k, base[3], span;
        logic [15:0] nn[3];
        logic [16:0] vis;
        k = longint'($urandom_range(1, 1 << ($urandom_range(0, 17))));
        span = (k * 16384) >> $urandom_range(0, 6);
        for (int j = 0; j < 3; j++) begin
            base[j] = longint'($signed(lax[16*j +: 16])) * k + spread(span);
            nn[j] = 16'(-longint'($signed(lax[16*j +: 16])) + spread(4000));
        end
        vis = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        return point_at(base[0], base[1], base[2], nn[0], nn[1], nn[2], vis);
    endfunction

    function automatic logic [47:0] rand_axis();
        logic [15:0] c[3];
        for (int j = 0; j < 3; j++) begin
            case ($urandom_range(3))
                0: c[j] = 16'd16384;
                1: c[j] = -16'sd16384;
                2: c[j] = 16'($urandom);
                default: c[j] = 16'($urandom_range(0, 32768) - 16384);
            endcase
        end
        return {c[2], c[1], c[0]};
    endfunction

    initial begin
        t_in_item    it;
        logic [15:0] ci, co;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        lx = 0; ly = 0; lz = 0; lax = AXIS_RESET;

        // reset values: on light, inner, penumbra, outside, saturation, extremes
        send(point_at(0, 0, 0, 16'h0, 16'h0, 16'h0, 17'd0));
        send(point_at(65536, 0, 0, -16'sd16384, 16'h0, 16'h0, 17'd65536));
        send(point_at(65536 * 10, 65536 * 3, 0, -16'sd16384, 16'h0, 16'h0, 17'd65536));
        send(point_at(65536 * 10, 65536 * 3 + 30000, 0, -16'sd16384, 16'h0, 16'h0,
                      17'd40000));
        send(point_at(65536 * 10, 65536 * 8, 0, -16'sd16384, 16'h0, 16'h0, 17'd65536));
        send(point_at(-65536, 0, 0, 16'sd16384, 16'h0, 16'h0, 17'd65536));
        send(point_at(1, 0, 0, -16'sd16384, 16'h0, 16'h0, 17'h1FFFF));
        send(point_at(1000, 1, 1, 16'h8000, 16'h7FFF, 16'h8000, 17'h1FFFF));
        send(point_at(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      16'h8000, 16'h8000, 16'h8000, 17'd65536));
        send(point_at(-32'sh80000000, -32'sh80000000, -32'sh80000000,
                      16'h7FFF, 16'h7FFF, 16'h7FFF, 17'd1));
        send(point_at(3, 0, 0, 16'h0, 16'h0, 16'h0, 17'd65536));
        set_light(32'h80000000, 32'h80000000, 32'h80000000, 48'h4000_4000_4000,
                  16'sd16384, -16'sd16384, 32'hFFFFFFFF);
        send(point_at(64'hFFFFFFFF, 64'hFFFFFFFF, 64'hFFFFFFFF,
                      16'hC000, 16'hC000, 16'hC000, 17'h1FFFF));
        send(point_at(1, 1, 1, 16'hC000, 16'hC000, 16'hC000, 17'h1FFFF));
        send(point_at(0, 0, 0, 16'hC000, 16'hC000, 16'hC000, 17'h1FFFF));
        set_light(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 48'hC000_0000_C000,
                  -16'sd16384, 16'sd16384, 32'h0);
        send(point_at(-64'h7FFFFFFF, 0, 5, 16'h4000, 16'h0, 16'h4000, 17'd65536));
        send(point_at(-20, 0, -20, 16'h4000, 16'h0, 16'h4000, 17'd65536));
        send(point_at(20, 0, 20, 16'h4000, 16'h0, 16'h4000, 17'd65536));

        for (int p = 0; p < 9; p++) begin
            ci = 16'($urandom_range(0, 32768) - 16384);
            co = 16'($urandom_range(0, 32768) - 16384);
            if (p % 4 != 3 && $signed(ci) < $signed(co)) {ci, co} = {co, ci};
            set_light(($urandom_range(1)) ? 32'($urandom) : 32'($urandom_range(0, 1 << 22)),
                      32'($urandom), 32'($urandom_range(0, 1 << 20)), rand_axis(), ci, co,
                      ($urandom_range(1)) ? 32'($urandom) : 32'($urandom_range(0, 1 << 18)));
            for (int n = 0; n < 180; n++) begin
                calm = (sent >= 700 && sent < 1000);
                if ($urandom_range(99) < 80) begin
                    send(cone_point());
                end else begin
                    it = t_in_item'($bits(t_in_item)'({$urandom, $urandom, $urandom,
                                                       $urandom, $urandom, $urandom}));
                    send(it);
                end
            end
        end
        calm = 1'b0;
        drain();
        repeat (120) @(posedge i_clk);
        $display("sent %0d points under %0d light settings, %0d results checked",
                 sent, phases, results);
        if (errors == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/slcd_pkg.sv
rtl/slcd_sqrt_cell.sv
rtl/slcd_div_cell.sv
rtl/spot_light_cone_diffuse.sv
tb/sv/slcd_checker.sv
tb/sv/testbench.sv
